FILE: src/mexp_pkg.sv
// Package for the modular exponentiation block: widths, command/status
// structs and the modular add used by the datapath. No dependencies.
`default_nettype none

package mexp_pkg;

  localparam int unsigned WIDTH = 32;
  localparam int unsigned CNT_W = $clog2(WIDTH);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

  typedef logic [WIDTH-1:0] word_t;

  // controller -> datapath
  typedef struct packed {
    logic load;         // capture a new transaction
    logic red_step;     // one bit of base reduction
    logic mul_start;    // clear partial product, pick multiplier operand
    logic mul_sel_acc;  // multiplier operand is acc (else sq)
    logic mul_step;     // one bit of interleaved modular multiply
    logic e_shift;      // exponent >> 1
    logic out_load;     // copy acc into output register
  } mexp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic n_zero;
    logic cnt_last;
    logic e_zero;
    logic e_lsb;
    logic e_next_zero;
  } mexp_sts_t;

  // (x + y) mod n for x, y < n; n == 0 wraps at 2^WIDTH
  function automatic word_t add_mod(input word_t x, input word_t y, input word_t n);
    logic [WIDTH:0] s;
    s = {1'b0, x} + {1'b0, y};
    if ((n != '0) && (s >= {1'b0, n})) begin
      s = s - {1'b0, n};
    end
    return s[WIDTH-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: src/mexp_datapath.sv
// Datapath: modulus register, base reduction, bit-serial modular multiply,
// exponent shifter and output register. Depends on mexp_pkg.
`default_nettype none

module mexp_datapath
  import mexp_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      cfg_we_i,
  input  wire word_t     cfg_wdata_i,
  input  wire word_t     base_i,
  input  wire word_t     exponent_i,
  input  wire mexp_cmd_t cmd_i,
  output mexp_sts_t      sts_o,
  output word_t          power_mod_o
);

  word_t            n_q;
  word_t            sq_q, sq_d;
  word_t            acc_q, acc_d;
  word_t            e_q, e_d;
  word_t            r_q, r_d;
  word_t            b_q, b_d;
  word_t            out_q, out_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             mul_acc_q, mul_acc_d;

  word_t          red_next;
  word_t          mul_dbl;
  word_t          mul_next;
  logic [WIDTH:0] red_t;

  // restoring remainder step: shift in next base bit, subtract n if it fits
  always_comb begin
    red_t = {r_q, b_q[WIDTH-1]};
    if (red_t >= {1'b0, n_q}) begin
      red_t = red_t - {1'b0, n_q};
    end
    red_next = red_t[WIDTH-1:0];
  end

  // interleaved multiply: r = 2r (+ sq) mod n, multiplier bits MSB first
  always_comb begin
    mul_dbl  = add_mod(r_q, r_q, n_q);
    mul_next = b_q[WIDTH-1] ? add_mod(mul_dbl, sq_q, n_q) : mul_dbl;
  end

  always_comb begin
    sq_d      = sq_q;
    acc_d     = acc_q;
    e_d       = e_q;
    r_d       = r_q;
    b_d       = b_q;
    out_d     = out_q;
    cnt_d     = cnt_q;
    mul_acc_d = mul_acc_q;

    if (cmd_i.load) begin
      sq_d  = base_i;
      b_d   = base_i;
      e_d   = exponent_i;
      acc_d = WIDTH'(1);
      r_d   = '0;
      cnt_d = '0;
    end
    if (cmd_i.red_step) begin
      r_d   = red_next;
      b_d   = b_q << 1;
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_LAST) begin
        sq_d = red_next;
      end
    end
    if (cmd_i.mul_start) begin
      r_d       = '0;
      cnt_d     = '0;
      b_d       = cmd_i.mul_sel_acc ? acc_q : sq_q;
      mul_acc_d = cmd_i.mul_sel_acc;
    end
    if (cmd_i.mul_step) begin
      r_d   = mul_next;
      b_d   = b_q << 1;
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_LAST) begin
        if (mul_acc_q) begin
          acc_d = mul_next;
        end else begin
          sq_d = mul_next;
        end
      end
    end
    if (cmd_i.e_shift) begin
      e_d = e_q >> 1;
    end
    if (cmd_i.out_load) begin
      out_d = acc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q       <= WIDTH'(1);
      cnt_q     <= '0;
      mul_acc_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        n_q <= cfg_wdata_i;
      end
      cnt_q     <= cnt_d;
      mul_acc_q <= mul_acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q  <= sq_d;
    acc_q <= acc_d;
    e_q   <= e_d;
    r_q   <= r_d;
    b_q   <= b_d;
    out_q <= out_d;
  end

  assign sts_o.n_zero      = (n_q == '0);
  assign sts_o.cnt_last    = (cnt_q == CNT_LAST);
  assign sts_o.e_zero      = (e_q == '0);
  assign sts_o.e_lsb       = e_q[0];
  assign sts_o.e_next_zero = (e_q[WIDTH-1:1] == '0);
  assign power_mod_o       = out_q;

endmodule

`default_nettype wire

FILE: src/mexp_ctrl.sv
// Controller: one-hot sequencer for reduce / multiply / square and the
// input/output handshakes. Depends on mexp_pkg.
`default_nettype none

module mexp_ctrl
  import mexp_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  input  wire mexp_sts_t sts_i,
  output mexp_cmd_t      cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_REDUCE  = 7'b0000010,
    S_CHECK   = 7'b0000100,
    S_MUL_ACC = 7'b0001000,
    S_SQ_INIT = 7'b0010000,
    S_MUL_SQ  = 7'b0100000,
    S_DONE    = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          // zero modulus: products wrap, base is used as is
          state_d = sts_i.n_zero ? S_CHECK : S_REDUCE;
        end
      end
      S_REDUCE: begin
        cmd_o.red_step = 1'b1;
        if (sts_i.cnt_last) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.e_zero) begin
          state_d = S_DONE;
        end else begin
          cmd_o.mul_start   = 1'b1;
          cmd_o.mul_sel_acc = sts_i.e_lsb;
          state_d = sts_i.e_lsb ? S_MUL_ACC : S_MUL_SQ;
        end
      end
      S_MUL_ACC: begin
        cmd_o.mul_step = 1'b1;
        if (sts_i.cnt_last) begin
          if (sts_i.e_next_zero) begin
            // last exponent bit: the square would go unused
            cmd_o.e_shift = 1'b1;
            state_d = S_CHECK;
          end else begin
            state_d = S_SQ_INIT;
          end
        end
      end
      S_SQ_INIT: begin
        cmd_o.mul_start = 1'b1;
        state_d = S_MUL_SQ;
      end
      S_MUL_SQ: begin
        cmd_o.mul_step = 1'b1;
        if (sts_i.cnt_last) begin
          cmd_o.e_shift = 1'b1;
          state_d = S_CHECK;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

FILE: src/modular_exponentiation.sv
// Sequence: accept, then bit-serial base reduction (skipped for modulus 0);
//   per exponent bit a setup and a bit-serial multiply, with a second setup
//   and multiply (the square) for a set bit below the top one; then a final
//   check and an output load. A zero exponent skips the per-bit steps.
// Flow: one transaction at a time, set by the bit-serial multiplier; a new
//   base/exponent is taken while a result waits.
// Reset (rst_ni, async low): idle, no result pending, modulus = 1.
//
// Top level of the modular exponentiation block. Depends on mexp_pkg,
// mexp_ctrl and mexp_datapath.
`default_nettype none

module modular_exponentiation
  import mexp_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  // modulus register write
  input  wire logic  cfg_we_i,
  input  wire word_t cfg_wdata_i,
  // input transaction
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire word_t base_i,
  input  wire word_t exponent_i,
  // result transaction
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output word_t      power_mod_o
);

  // Right-to-left square-and-multiply. The base is first reduced mod n by a
  // bit-serial restoring remainder, so every multiplicand is below n. Each
  // modular multiply then walks the multiplier MSB first: r = 2r (+ sq) mod n,
  // one bit per cycle, with two conditional-subtract adders in the path.
  // acc starts at 1 and is only replaced by a finished product, so a zero
  // exponent returns 1 even when the modulus is 1.

  mexp_cmd_t cmd;
  mexp_sts_t sts;

  mexp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mexp_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .base_i      (base_i),
    .exponent_i  (exponent_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .power_mod_o (power_mod_o)
  );

endmodule

`default_nettype wire
